FILE: design/one_shot_timer_queue_defines.svh
// assertion macros shared by the timer queue modules
`ifndef ONE_SHOT_TIMER_QUEUE_DEFINES_SVH
`define ONE_SHOT_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define OTQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OTQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/otq_pkg.sv
// shared types and constants for the one-shot timer queue
package otq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int REQ_W = 2;
	localparam int ST_W  = 2;
	localparam int DL_W  = 48;
	localparam int ID_W  = 32;
	localparam int CL_W  = 32;

	typedef enum logic [REQ_W-1:0] {
		REQ_SCHEDULE = 2'd0,
		REQ_CANCEL   = 2'd1,
		REQ_TICK     = 2'd2
	} req_t;

	typedef enum logic [ST_W-1:0] {
		RES_ACCEPTED  = 2'd0,
		RES_REJECTED  = 2'd1,
		RES_FIRED     = 2'd2,
		RES_TICK_DONE = 2'd3
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCHED,
		S_CANCEL,
		S_TICK
	} state_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_SCHED,
		EMIT_CANCEL,
		EMIT_FIRE,
		EMIT_TICK_DONE
	} emit_t;

	typedef struct packed {
		logic  capture;
		logic  scan_start;
		logic  scan_step;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic best_found;
	} sts_t;

endpackage

FILE: design/otq_ram.sv
// generic single-write, single-read ram with registered read data
module otq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/otq_ctrl.sv
// controller state machine for the timer queue
`include "one_shot_timer_queue_defines.svh"

module otq_ctrl import otq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [REQ_W-1:0] req_type,
	input  sts_t             sts,
	output logic             busy,
	output cmd_t             cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req_type)
						REQ_SCHEDULE: state_d = S_SCHED;
						REQ_CANCEL:   state_d = S_CANCEL;
						REQ_TICK:     state_d = S_TICK;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_SCHED: state_d = S_IDLE;
			S_CANCEL: begin
				if (sts.scan_done) begin
					state_d = S_IDLE;
				end
			end
			S_TICK: begin
				if (sts.scan_done && !sts.best_found) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy           = 1'b1;
		cmd.capture    = 1'b0;
		cmd.scan_start = 1'b0;
		cmd.scan_step  = 1'b0;
		cmd.emit       = EMIT_NONE;
		case (state_q)
			S_IDLE: begin
				busy           = 1'b0;
				cmd.capture    = start;
				cmd.scan_start = start && (req_type == REQ_CANCEL || req_type == REQ_TICK);
			end
			S_SCHED: begin
				cmd.emit = EMIT_SCHED;
			end
			S_CANCEL: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					cmd.emit = EMIT_CANCEL;
				end
			end
			S_TICK: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					if (sts.best_found) begin
						cmd.emit       = EMIT_FIRE;
						cmd.scan_start = 1'b1;
					end else begin
						cmd.emit = EMIT_TICK_DONE;
					end
				end
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	`OTQ_ASSERT_NEXT(a_accept_goes_busy, start && !busy && (req_type == REQ_SCHEDULE || req_type == REQ_CANCEL || req_type == REQ_TICK), busy, "valid request did not make the block busy")
	`OTQ_ASSERT_NOW(a_tick_done_after_clean_scan, cmd.emit == EMIT_TICK_DONE, sts.scan_done && !sts.best_found, "tick closed with a due timer left")
	`OTQ_ASSERT_NEXT(a_fire_rescans, cmd.emit == EMIT_FIRE, busy && !sts.scan_done, "fired timer not followed by a new scan")

endmodule

FILE: design/otq_datapath.sv
// timer table, slot scan and result registers
`include "one_shot_timer_queue_defines.svh"

module otq_datapath import otq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [DL_W-1:0]  deadline_ms,
	input  logic [CL_W-1:0]  client_ref,
	input  logic [ID_W-1:0]  cancel_id,
	input  logic [DL_W-1:0]  now_ms,
	output logic             result_valid,
	output logic [ST_W-1:0]  status,
	output logic [ID_W-1:0]  timer_id,
	output logic [CL_W-1:0]  fired_client,
	output logic             last
);

	localparam int RW = DL_W + ID_W + CL_W;
	localparam int KW = DL_W + ID_W;

	logic [CAPACITY-1:0] valid_q;
	logic [ID_W-1:0]     next_id_q;
	logic [ID_W-1:0]     id_inc;
	logic [DL_W-1:0]     deadline_q;
	logic [DL_W-1:0]     now_q;
	logic [CL_W-1:0]     client_q;
	logic [ID_W-1:0]     cancel_id_q;

	logic                free_found;
	logic [AW-1:0]       free_slot;
	logic                we;

	logic [AW-1:0]       addr_q;
	logic                issued_q;
	logic                rd_en;
	logic                rd_vld_s1;
	logic [AW-1:0]       slot_s1;
	logic [RW-1:0]       rdata;
	logic [DL_W-1:0]     rd_dl;
	logic [ID_W-1:0]     rd_id;
	logic [CL_W-1:0]     rd_cl;

	logic                hit;
	logic                cancel_hit;
	logic                take_best;
	logic                match_found_q;
	logic [AW-1:0]       match_slot_q;
	logic                best_found_q;
	logic [AW-1:0]       best_slot_q;
	logic [KW-1:0]       best_key_q;
	logic [CL_W-1:0]     best_client_q;

	logic                result_valid_q;
	logic [ST_W-1:0]     status_q;
	logic [ID_W-1:0]     timer_id_q;
	logic [CL_W-1:0]     fired_client_q;
	logic                last_q;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_slot  = AW'(i);
			end
		end
	end

	assign we     = (cmd.emit == EMIT_SCHED) && free_found;
	assign id_inc = next_id_q + ID_W'(1);
	assign rd_en  = cmd.scan_step && !issued_q;

	otq_ram #(
		.WIDTH(RW),
		.DEPTH(CAPACITY)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(free_slot),
		.wdata({deadline_q, next_id_q, client_q}),
		.re   (rd_en),
		.raddr(addr_q),
		.rdata(rdata)
	);

	assign rd_dl = rdata[RW-1 -: DL_W];
	assign rd_id = rdata[CL_W +: ID_W];
	assign rd_cl = rdata[CL_W-1:0];

	assign hit        = rd_vld_s1 && valid_q[slot_s1];
	assign cancel_hit = hit && (rd_id == cancel_id_q) && !match_found_q;
	assign take_best  = hit && (rd_dl < now_q) &&
		(!best_found_q || ({rd_dl, rd_id} < best_key_q));

	assign sts.scan_done  = issued_q && !rd_vld_s1;
	assign sts.best_found = best_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			next_id_q      <= ID_W'(1);
			addr_q         <= '0;
			issued_q       <= 1'b0;
			rd_vld_s1      <= 1'b0;
			match_found_q  <= 1'b0;
			best_found_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (cmd.emit != EMIT_NONE);
			if (we) begin
				valid_q[free_slot] <= 1'b1;
				next_id_q          <= (id_inc == '0) ? ID_W'(1) : id_inc;
			end
			if (cmd.emit == EMIT_CANCEL && match_found_q) begin
				valid_q[match_slot_q] <= 1'b0;
			end
			if (cmd.emit == EMIT_FIRE) begin
				valid_q[best_slot_q] <= 1'b0;
			end
			if (cmd.scan_start) begin
				addr_q        <= '0;
				issued_q      <= 1'b0;
				rd_vld_s1     <= 1'b0;
				match_found_q <= 1'b0;
				best_found_q  <= 1'b0;
			end else begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					if (addr_q == AW'(CAPACITY - 1)) begin
						issued_q <= 1'b1;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				if (cancel_hit) begin
					match_found_q <= 1'b1;
				end
				if (take_best) begin
					best_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			deadline_q  <= deadline_ms;
			client_q    <= client_ref;
			cancel_id_q <= cancel_id;
			now_q       <= now_ms;
		end
		if (rd_en) begin
			slot_s1 <= addr_q;
		end
		if (cancel_hit) begin
			match_slot_q <= slot_s1;
		end
		if (take_best) begin
			best_slot_q   <= slot_s1;
			best_key_q    <= {rd_dl, rd_id};
			best_client_q <= rd_cl;
		end
		case (cmd.emit)
			EMIT_SCHED: begin
				status_q       <= free_found ? RES_ACCEPTED : RES_REJECTED;
				timer_id_q     <= free_found ? next_id_q : '0;
				fired_client_q <= '0;
				last_q         <= 1'b1;
			end
			EMIT_CANCEL: begin
				status_q       <= match_found_q ? RES_ACCEPTED : RES_REJECTED;
				timer_id_q     <= cancel_id_q;
				fired_client_q <= '0;
				last_q         <= 1'b1;
			end
			EMIT_FIRE: begin
				status_q       <= RES_FIRED;
				timer_id_q     <= best_key_q[ID_W-1:0];
				fired_client_q <= best_client_q;
				last_q         <= 1'b0;
			end
			EMIT_TICK_DONE: begin
				status_q       <= RES_TICK_DONE;
				timer_id_q     <= '0;
				fired_client_q <= '0;
				last_q         <= 1'b1;
			end
			default: begin
				last_q <= last_q;
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign timer_id     = timer_id_q;
	assign fired_client = fired_client_q;
	assign last         = last_q;

	`OTQ_ASSERT_NEXT(a_no_back_to_back, result_valid_q, !result_valid_q, "results on consecutive cycles")
	`OTQ_ASSERT_NEXT(a_fire_frees_slot, cmd.emit == EMIT_FIRE, !valid_q[$past(best_slot_q)], "fired timer still pending")
	`OTQ_ASSERT_NOW(a_id_never_zero, 1'b1, next_id_q != '0, "id counter reached zero")

endmodule

FILE: design/one_shot_timer_queue.sv
// top level of the one-shot timer queue
// schedule: result strobe is registered from the SCHED state, next start accepted in the strobe cycle
// cancel: one slot read per cycle over the whole table, then a registered result
// tick: each fired timer costs one full table scan
// tick total: fired+1 table scans, set by the single table read port
// reset clears all pending timers and sets the next id to one; no clearing pass
module one_shot_timer_queue import otq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [REQ_W-1:0] req_type,
	input  logic [DL_W-1:0]  deadline_ms,
	input  logic [CL_W-1:0]  client_ref,
	input  logic [ID_W-1:0]  cancel_id,
	input  logic [DL_W-1:0]  now_ms,
	output logic             result_valid,
	output logic [ST_W-1:0]  status,
	output logic [ID_W-1:0]  timer_id,
	output logic [CL_W-1:0]  fired_client,
	output logic             last
);

	cmd_t cmd;
	sts_t sts;

	otq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req_type),
		.sts     (sts),
		.busy    (busy),
		.cmd     (cmd)
	);

	otq_datapath #(
		.CAPACITY(CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.deadline_ms (deadline_ms),
		.client_ref  (client_ref),
		.cancel_id   (cancel_id),
		.now_ms      (now_ms),
		.result_valid(result_valid),
		.status      (status),
		.timer_id    (timer_id),
		.fired_client(fired_client),
		.last        (last)
	);

endmodule
